// File: hdl/md5_digest_stream_macros.svh
// ----------------------------------------------------------------------------
// md5_digest_stream_macros.svh
// Assertion macros used by the verification checker.
// ----------------------------------------------------------------------------
`ifndef MD5_DIGEST_STREAM_MACROS_SVH
`define MD5_DIGEST_STREAM_MACROS_SVH

// clocked check, off while reset is high
`define MD5DS_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also holds through reset
`define MD5DS_CHECK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hdl/md5ds_pkg.sv
// ----------------------------------------------------------------------------
// md5ds_pkg
// Types, constants and round functions of the MD5 stream digest.
// ----------------------------------------------------------------------------
package md5ds_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_OUT
   } md5ds_state_type;

   localparam logic [31:0] INIT_A   = 32'h67452301;
   localparam logic [31:0] INIT_B   = 32'hefcdab89;
   localparam logic [31:0] INIT_C   = 32'h98badcfe;
   localparam logic [31:0] INIT_D   = 32'h10325476;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [5:0]  LEN_POS  = 6'd56;
   localparam logic [3:0]  LEN_LO_W = 4'd14;
   localparam logic [3:0]  LEN_HI_W = 4'd15;

   localparam logic [4:0] ROT_TABLE [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // message word used by a round
   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [3:0] i;
      logic [3:0] g;
      i = rnd[3:0];
      case (rnd[5:4])
         2'd0:    g = i;
         2'd1:    g = 4'(i * 4'd5 + 4'd1);
         2'd2:    g = 4'(i * 4'd3 + 4'd5);
         default: g = 4'(i * 4'd7);
      endcase
      return g;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
      return ROT_TABLE[{rnd[5:4], rnd[1:0]}];
   endfunction

   function automatic logic [31:0] round_f(input logic [5:0]  rnd,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
      logic [31:0] f;
      case (rnd[5:4])
         2'd0:    f = (b & c) | (~b & d);
         2'd1:    f = (d & b) | (~d & c);
         2'd2:    f = b ^ c ^ d;
         default: f = c ^ (b | ~d);
      endcase
      return f;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
      logic [63:0] w;
      w = {v, v} << n;
      return w[63:32];
   endfunction

endpackage

// File: hdl/md5_digest_stream.sv
// ----------------------------------------------------------------------------
// md5_digest_stream
// MD5 digest of a byte stream; one 128-bit digest per message.
// A byte is taken only while idle; the byte that completes a 64-byte block starts
// the 64 rounds, one round per cycle on the single block-word memory.
// Message end: padding words are written, rounds run on each padded block, then
// the digest goes to the output register. New bytes wait while the block is busy.
// Reset (synchronous): chaining words to the MD5 initial values, count to 0.
// ----------------------------------------------------------------------------
module md5_digest_stream
   import md5ds_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // is_last
   input  logic         req_tuser,   // [0] no_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // [31:0] digest_a, [63:32] digest_b,
                                     // [95:64] digest_c, [127:96] digest_d
);

   md5ds_state_type state_ff, state_in;
   logic [60:0]  cnt_ff, cnt_in;
   logic [23:0]  pack_ff, pack_in;
   logic [3:0]   pad_w_ff, pad_w_in;
   logic         first_ff, first_in;
   logic         final_ff, final_in;
   logic         last_ff, last_in;
   logic         pad2_ff, pad2_in;
   logic [5:0]   round_ff, round_in;
   logic [31:0]  wa_ff, wa_in, wb_ff, wb_in, wc_ff, wc_in, wd_ff, wd_in;
   logic [31:0]  chain_a_ff, chain_a_in, chain_b_ff, chain_b_in;
   logic [31:0]  chain_c_ff, chain_c_in, chain_d_ff, chain_d_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_data_ff, rsp_data_in;

   logic [31:0]  words_mem [16];
   logic [31:0]  rd_data_ff;
   logic [3:0]   rd_addr;
   logic         we;
   logic [3:0]   wr_addr;
   logic [31:0]  wr_data;

   logic         accept;
   logic         has_byte;
   logic [60:0]  cnt_next;
   logic [5:0]   pad_pos;
   logic [31:0]  pad_word;
   logic [31:0]  t_sum;
   logic [31:0]  new_b;

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    pad_word = {24'h0, PAD_BYTE};
         2'd1:    pad_word = {16'h0, PAD_BYTE, pack_ff[7:0]};
         2'd2:    pad_word = {8'h0, PAD_BYTE, pack_ff[15:0]};
         default: pad_word = {PAD_BYTE, pack_ff[23:0]};
      endcase
      if (!first_ff) begin
         if (final_ff && pad_w_ff == LEN_LO_W) begin
            pad_word = {cnt_ff[28:0], 3'b000};
         end else if (final_ff && pad_w_ff == LEN_HI_W) begin
            pad_word = cnt_ff[60:29];
         end else begin
            pad_word = '0;
         end
      end
   end

   always_comb begin
      t_sum = round_f(round_ff, wb_ff, wc_ff, wd_ff) + wa_ff + ROUND_K[round_ff] + rd_data_ff;
      new_b = wb_ff + rotl32(t_sum, rot_amount(round_ff));
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pack_in      = pack_ff;
      pad_w_in     = pad_w_ff;
      first_in     = first_ff;
      final_in     = final_ff;
      last_in      = last_ff;
      pad2_in      = pad2_ff;
      round_in     = round_ff;
      wa_in        = wa_ff;
      wb_in        = wb_ff;
      wc_in        = wc_ff;
      wd_in        = wd_ff;
      chain_a_in   = chain_a_ff;
      chain_b_in   = chain_b_ff;
      chain_c_in   = chain_c_ff;
      chain_d_in   = chain_d_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      we           = 1'b0;
      wr_addr      = cnt_ff[5:2];
      wr_data      = {req_tdata, pack_ff};
      rd_addr      = '0;
      req_tready   = (state_ff == ST_IDLE);
      accept       = req_tvalid && req_tready;
      has_byte     = !req_tuser;
      cnt_next     = cnt_ff + 61'd1;
      pad_pos      = (state_ff == ST_IDLE && has_byte) ? cnt_next[5:0] : cnt_ff[5:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (has_byte) begin
                  cnt_in = cnt_next;
                  unique case (cnt_ff[1:0])
                     2'd0:    pack_in[7:0]   = req_tdata;
                     2'd1:    pack_in[15:8]  = req_tdata;
                     2'd2:    pack_in[23:16] = req_tdata;
                     default: we = 1'b1;
                  endcase
               end
               if (has_byte && cnt_ff[5:0] == 6'd63) begin
                  state_in = ST_ROUND;
                  round_in = '0;
                  wa_in    = chain_a_ff;
                  wb_in    = chain_b_ff;
                  wc_in    = chain_c_ff;
                  wd_in    = chain_d_ff;
                  last_in  = req_tlast;
                  final_in = 1'b0;
                  pad2_in  = 1'b0;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
                  pad_w_in = pad_pos[5:2];
                  first_in = 1'b1;
                  final_in = (pad_pos < LEN_POS);
                  pad2_in  = (pad_pos >= LEN_POS);
                  last_in  = 1'b0;
               end
            end
         end
         ST_PAD: begin
            we       = 1'b1;
            wr_addr  = pad_w_ff;
            wr_data  = pad_word;
            first_in = 1'b0;
            pad_w_in = pad_w_ff + 4'd1;
            if (pad_w_ff == LEN_HI_W) begin
               state_in = ST_ROUND;
               round_in = '0;
               wa_in    = chain_a_ff;
               wb_in    = chain_b_ff;
               wc_in    = chain_c_ff;
               wd_in    = chain_d_ff;
            end
         end
         ST_ROUND: begin
            rd_addr  = msg_index(round_ff + 6'd1);
            round_in = round_ff + 6'd1;
            wa_in    = wd_ff;
            wb_in    = new_b;
            wc_in    = wb_ff;
            wd_in    = wc_ff;
            if (round_ff == 6'd63) begin
               chain_a_in = chain_a_ff + wd_ff;
               chain_b_in = chain_b_ff + new_b;
               chain_c_in = chain_c_ff + wb_ff;
               chain_d_in = chain_d_ff + wc_ff;
               if (final_ff) begin
                  state_in = ST_OUT;
               end else if (last_ff) begin
                  state_in = ST_PAD;
                  pad_w_in = pad_pos[5:2];
                  first_in = 1'b1;
                  final_in = (pad_pos < LEN_POS);
                  pad2_in  = (pad_pos >= LEN_POS);
                  last_in  = 1'b0;
               end else if (pad2_ff) begin
                  state_in = ST_PAD;
                  pad_w_in = '0;
                  first_in = 1'b0;
                  final_in = 1'b1;
                  pad2_in  = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {chain_d_ff, chain_c_ff, chain_b_ff, chain_a_ff};
               rsp_valid_in = 1'b1;
               chain_a_in   = INIT_A;
               chain_b_in   = INIT_B;
               chain_c_in   = INIT_C;
               chain_d_in   = INIT_D;
               cnt_in       = '0;
               final_in     = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         first_ff     <= 1'b0;
         final_ff     <= 1'b0;
         last_ff      <= 1'b0;
         pad2_ff      <= 1'b0;
         round_ff     <= '0;
         chain_a_ff   <= INIT_A;
         chain_b_ff   <= INIT_B;
         chain_c_ff   <= INIT_C;
         chain_d_ff   <= INIT_D;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         first_ff     <= first_in;
         final_ff     <= final_in;
         last_ff      <= last_in;
         pad2_ff      <= pad2_in;
         round_ff     <= round_in;
         chain_a_ff   <= chain_a_in;
         chain_b_ff   <= chain_b_in;
         chain_c_ff   <= chain_c_in;
         chain_d_ff   <= chain_d_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pack_ff     <= pack_in;
      pad_w_ff    <= pad_w_in;
      wa_ff       <= wa_in;
      wb_ff       <= wb_in;
      wc_ff       <= wc_in;
      wd_ff       <= wd_in;
      rsp_data_ff <= rsp_data_in;
   end

   // block words: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         words_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= words_mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: hdl/md5ds_checker.sv
// ----------------------------------------------------------------------------
// md5ds_checker
// Port-level checks of the MD5 stream digest, bound to the top level.
// ----------------------------------------------------------------------------
`include "md5_digest_stream_macros.svh"

module md5ds_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [7:0]   req_tdata,
   input logic         req_tlast,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata
);

   logic req_fire;
   logic rsp_stall;
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `MD5DS_CHECK(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "digest not held")
   `MD5DS_CHECK_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "digest valid after reset")
   `MD5DS_CHECK(a_last_busy, req_fire && req_tlast |=> !req_tready, "request taken in padding")
   `MD5DS_CHECK(a_no_early_rsp, req_fire |=> !$rose(rsp_tvalid), "early digest")

endmodule

bind md5_digest_stream md5ds_checker u_md5ds_checker (.*);
